// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tile decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/cgd_pkg.sv -----
// ----------------------------------------------------------------------------
// cgd_pkg
// Widths, codes and beat types shared by the tile decoder modules.
// ----------------------------------------------------------------------------
package cgd_pkg;

    localparam int VALUE_W      = 32;
    localparam int GID_W        = 29;
    localparam int POS_W        = 12;
    localparam int SET_INDEX_W  = 2;
    localparam int SET_COUNT_W  = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int NUM_GID_REGS = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam int NUM_SETS_DEF = 4;
    localparam int MAX_DIM_DEF  = 4096;

    localparam int FLAG_H_BIT = 31;
    localparam int FLAG_V_BIT = 30;
    localparam int FLAG_D_BIT = 29;

    localparam logic [SET_COUNT_W-1:0] SET_COUNT_RESET = SET_COUNT_W'(1);
    localparam logic [GID_W-1:0]       FIRST_GID_RESET = GID_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_GID_0 = CFG_IDX_W'(1);

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef struct packed {
        logic       layer_start;
        logic [7:0] text_char;
    } char_beat_t;

    typedef struct packed {
        logic [POS_W-1:0]       tile_col;
        logic [POS_W-1:0]       tile_row;
        logic [SET_INDEX_W-1:0] set_index;
        logic [GID_W-1:0]       local_id;
        logic                   set_found;
        logic                   flip_horiz;
        logic                   flip_vert;
        logic                   flip_diag;
    } tile_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] raw;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
    } field_beat_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

// ----- hw/rtl/cgd_front.sv -----
// ----------------------------------------------------------------------------
// cgd_front
// Character parser: builds field values, tracks row and column, and
// pushes one field beat per terminated nonblank field not 0 or all ones.
// ----------------------------------------------------------------------------
module cgd_front #(
    parameter int MAX_DIM = cgd_pkg::MAX_DIM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    input  cgd_pkg::char_beat_t  char_beat,
    input  cgd_pkg::q_status_t   q_status,
    output logic                 push,
    output cgd_pkg::field_beat_t push_beat
);
    import cgd_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIM - 1);

    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic               seen_reg, seen_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic               accept;
    logic               due;
    logic [7:0]         digit;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    assign accept = char_valid && !q_status.full;
    assign due    = seen_reg && (accum_reg != '0) && (accum_reg != '1);
    assign digit  = char_beat.text_char - CHAR_ZERO;

    assign push_beat.raw = accum_reg;
    assign push_beat.col = POS_W'(col_reg);
    assign push_beat.row = POS_W'(row_reg);

    always_comb
    begin
        accum_next = accum_reg;
        seen_next  = seen_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (char_beat.layer_start)
            begin
                accum_next = '0;
                seen_next  = 1'b0;
                col_next   = '0;
                row_next   = '0;
            end
            else
            begin
                case (char_beat.text_char) inside
                    [CHAR_ZERO:CHAR_NINE]:
                    begin
                        accum_next = (accum_reg << 3) + (accum_reg << 1) + VALUE_W'(digit);
                        seen_next  = 1'b1;
                    end
                    CHAR_COMMA:
                    begin
                        push       = due;
                        accum_next = '0;
                        seen_next  = 1'b0;
                        col_next   = sat_inc(col_reg);
                    end
                    CHAR_NEWLINE:
                    begin
                        push       = due;
                        accum_next = '0;
                        seen_next  = 1'b0;
                        col_next   = '0;
                        row_next   = sat_inc(row_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            seen_reg  <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            accum_reg <= accum_next;
            seen_reg  <= seen_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ----- hw/rtl/cgd_fifo.sv -----
// ----------------------------------------------------------------------------
// cgd_fifo
// Short queue of field beats between the parser and the tileset lookup.
// ----------------------------------------------------------------------------
module cgd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cgd_pkg::field_beat_t push_beat,
    input  logic                 pop,
    output cgd_pkg::field_beat_t head_beat,
    output cgd_pkg::q_status_t   q_status
);
    import cgd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    field_beat_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_beat      = slot_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.avail = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/cgd_back.sv -----
// ----------------------------------------------------------------------------
// cgd_back
// Tileset registers, parallel first-id search and the tile output register.
// ----------------------------------------------------------------------------
module cgd_back #(
    parameter int NUM_SETS = cgd_pkg::NUM_SETS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [cgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cgd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  cgd_pkg::q_status_t                q_status,
    input  cgd_pkg::field_beat_t              head_beat,
    output logic                              pop,
    output logic                              tile_valid,
    input  logic                              tile_stall,
    output cgd_pkg::tile_beat_t               tile_beat
);
    import cgd_pkg::*;

    localparam int IDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    logic [SET_COUNT_W-1:0] set_count_reg;
    logic [GID_W-1:0]       first_gid_reg [NUM_SETS];
    logic [GID_W:0]         diff [NUM_SETS];
    logic [GID_W-1:0]       gid;
    logic                   found;
    logic [IDX_W-1:0]       idx;
    logic [GID_W-1:0]       local_id;
    tile_beat_t             result;
    logic                   tile_valid_reg, tile_valid_next;
    tile_beat_t             tile_beat_reg;

    assign gid = head_beat.raw[GID_W-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_SETS; i++)
        begin
            diff[i] = {1'b0, gid} - {1'b0, first_gid_reg[i]};
        end
    end

    always_comb
    begin
        found    = 1'b0;
        idx      = '0;
        local_id = '0;
        for (int i = 0; i < NUM_SETS; i++)
        begin
            if ((set_count_reg > SET_COUNT_W'(i)) && !diff[i][GID_W])
            begin
                found    = 1'b1;
                idx      = IDX_W'(i);
                local_id = diff[i][GID_W-1:0];
            end
        end
    end

    always_comb
    begin
        result.tile_col   = head_beat.col;
        result.tile_row   = head_beat.row;
        result.set_index  = SET_INDEX_W'(idx);
        result.local_id   = local_id;
        result.set_found  = found;
        result.flip_horiz = head_beat.raw[FLAG_H_BIT];
        result.flip_vert  = head_beat.raw[FLAG_V_BIT];
        result.flip_diag  = head_beat.raw[FLAG_D_BIT];
    end

    assign pop = q_status.avail && (!tile_valid_reg || !tile_stall);

    always_comb
    begin
        if (pop)
        begin
            tile_valid_next = 1'b1;
        end
        else if (tile_stall)
        begin
            tile_valid_next = tile_valid_reg;
        end
        else
        begin
            tile_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg <= SET_COUNT_RESET;
            for (int i = 0; i < NUM_SETS; i++)
            begin
                first_gid_reg[i] <= FIRST_GID_RESET;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SET_COUNT)
            begin
                set_count_reg <= cfg_data[SET_COUNT_W-1:0];
            end
            for (int i = 0; i < NUM_SETS; i++)
            begin
                if ((i < NUM_GID_REGS) && (cfg_index == REG_FIRST_GID_0 + CFG_IDX_W'(i)))
                begin
                    first_gid_reg[i] <= cfg_data[GID_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_valid_reg <= 1'b0;
        end
        else
        begin
            tile_valid_reg <= tile_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tile_beat_reg <= result;
        end
    end

    assign tile_valid = tile_valid_reg;
    assign tile_beat  = tile_beat_reg;

endmodule

// ----- hw/rtl/csv_tile_gid_decoder.sv -----
// ----------------------------------------------------------------------------
// csv_tile_gid_decoder: CSV tile text to tile beats with tileset lookup
// Path: closing comma or newline beat, queue slot, tile output register.
// Throughput: 1 character per cycle until the 2-entry queue fills (char_stall).
// Reset: async active low; counters, queue and tile valid clear, registers 1.
// ----------------------------------------------------------------------------
module csv_tile_gid_decoder #(
    parameter int NUM_SETS = cgd_pkg::NUM_SETS_DEF,
    parameter int MAX_DIM  = cgd_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           char_valid,
    output logic                           char_stall,
    input  cgd_pkg::char_beat_t            char_beat,
    output logic                           tile_valid,
    input  logic                           tile_stall,
    output cgd_pkg::tile_beat_t            tile_beat,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cgd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cgd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cgd_pkg::*;

    logic        push;
    logic        pop;
    field_beat_t push_beat;
    field_beat_t head_beat;
    q_status_t   q_status;

    assign char_stall = q_status.full;
    assign cfg_ready  = 1'b1;

    cgd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_beat  (char_beat),
        .q_status   (q_status),
        .push       (push),
        .push_beat  (push_beat)
    );

    cgd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .pop       (pop),
        .head_beat (head_beat),
        .q_status  (q_status)
    );

    cgd_back #(
        .NUM_SETS (NUM_SETS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .head_beat  (head_beat),
        .pop        (pop),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .tile_beat  (tile_beat)
    );

endmodule

// ----- hw/rtl/cgd_checker.sv -----
// ----------------------------------------------------------------------------
// cgd_checker
// Port-level checks on the tile decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                char_stall,
    input logic                tile_valid,
    input logic                tile_stall,
    input cgd_pkg::tile_beat_t tile_beat
);
    import cgd_pkg::*;

    logic tile_held;
    logic miss_zero;

    assign tile_held = tile_valid && tile_stall;
    assign miss_zero = (tile_beat.set_index == '0) && (tile_beat.local_id == '0);

    `ASSERT_NEXT(a_tile_hold, clk, rst_n, tile_held, tile_valid && $stable(tile_beat))
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, tile_valid && !tile_beat.set_found, miss_zero)
    `ASSERT_IMPLIES(a_stall_needs_tile, clk, rst_n, char_stall, tile_valid)
    `ASSERT_NEXT(a_stall_from_block, clk, rst_n, !tile_held, !char_stall)

endmodule

bind csv_tile_gid_decoder cgd_checker u_cgd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_stall (char_stall),
    .tile_valid (tile_valid),
    .tile_stall (tile_stall),
    .tile_beat  (tile_beat)
);
